// ===== sv/terminal_line_edit_fifo_defines.svh =====
`ifndef TERMINAL_LINE_EDIT_FIFO_DEFINES_SVH
`define TERMINAL_LINE_EDIT_FIFO_DEFINES_SVH

`ifndef SYNTHESIS
// temporal property, checked outside reset
`define TLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// invariant on the current cycle
`define TLE_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define TLE_ASSERT(lbl, prop, msg)
`define TLE_ASSERT_NOW(lbl, expr, msg)
`endif

`endif

// ===== sv/tle_pkg.sv =====
package tle_pkg;

  localparam int DEPTH       = 64;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int SEQ_MAX     = 6;
  localparam int IDX_W       = $clog2(SEQ_MAX + 1);
  localparam int TDATA_OUT_W = 16;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CARET_OFS  = 8'h40;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic MODE_RX   = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_REFUSE = 2'd2;

  localparam logic REG_ECHO = 1'b0;
  localparam logic REG_LINE = 1'b1;

  // result sequence of one transaction
  typedef enum logic [2:0] {
    SEQ_PLAIN,
    SEQ_CARET,
    SEQ_CRLF,
    SEQ_BS_SHORT,
    SEQ_BS_LONG
  } seq_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } tle_cmd_t;

  typedef struct packed {
    logic has_results;
    logic slot_free;
    logic last_result;
  } tle_status_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [7:0] seq_byte(input seq_t s, input logic [IDX_W-1:0] i,
                                          input logic [7:0] b);
    case (s)
      SEQ_PLAIN:    seq_byte = b;
      SEQ_CARET:    seq_byte = (i == IDX_W'(0)) ? CH_CARET : b;
      SEQ_CRLF:     seq_byte = (i == IDX_W'(0)) ? CH_CR : CH_LF;
      SEQ_BS_SHORT: seq_byte = (i == IDX_W'(1)) ? CH_SP : CH_BS;
      SEQ_BS_LONG:  seq_byte = (i == IDX_W'(2) || i == IDX_W'(3)) ? CH_SP : CH_BS;
      default:      seq_byte = b;
    endcase
  endfunction

endpackage

// ===== sv/terminal_line_edit_fifo.sv =====
// Terminal receive line discipline over a 64-slot circular byte buffer (63 bytes usable).
// A stream transaction with tuser=0 delivers a received byte (CR becomes LF, stored unless
// full; with echo on, BS/DEL erase the newest byte unless it is LF, and erase sequences
// are echoed); tuser=1 is a read request that returns the oldest byte, '!' when empty,
// or a refusal (kind 2) when line mode is on and no complete line is buffered. Each
// input is captured, then the buffer is updated, then each result goes through the single
// output register, one per cycle unless m_tready stalls; no new input is taken before
// the last result is loaded. Each result carries tlast on the final one of its input
// and the empty/full/line flags after the update. Registers: 0x0 echo_enable, 0x4
// line_enable, both reset to 1; write them only while idle. No clearing pass after reset.
module terminal_line_edit_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // data_in
  input  logic                               s_tuser,   // mode
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // data_out[7:0], is_empty[8], is_full[9], line_ready[10], zero pad
  output logic [tle_pkg::TDATA_OUT_W-1:0]    m_tdata,
  output logic [1:0]                         m_tuser,   // kind
  output logic                               m_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import tle_pkg::*;

  tle_cmd_t    cmd;
  tle_status_t status;
  logic        echo_enable;
  logic        line_enable;

  assign pready = 1'b1;
  assign prdata = {31'b0, (paddr[2] == REG_LINE) ? line_enable : echo_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b1;
      line_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ECHO: echo_enable <= pwdata[0];
        REG_LINE: line_enable <= pwdata[0];
        default:  echo_enable <= echo_enable;
      endcase
    end
  end

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tle_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .echo_enable (echo_enable),
    .line_enable (line_enable),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

// ===== sv/tle_ram.sv =====
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tle_ctrl.sv =====
`include "terminal_line_edit_fifo_defines.svh"

module tle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  tle_pkg::tle_status_t status,
  output tle_pkg::tle_cmd_t    cmd
);

  import tle_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.has_results ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          cmd.load = 1'b1;
          if (status.last_result) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TLE_ASSERT(a_capture_exec, cmd.capture |=> state == ST_EXEC, "capture not followed by exec")
  `TLE_ASSERT(a_exec_single, (state == ST_EXEC) |=> (state == ST_IDLE || state == ST_EMIT), "exec held over")

endmodule

// ===== sv/tle_datapath.sv =====
`include "terminal_line_edit_fifo_defines.svh"

module tle_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tle_pkg::tle_cmd_t                   cmd,
  output tle_pkg::tle_status_t                status,
  input  logic                                echo_enable,
  input  logic                                line_enable,
  input  logic [7:0]                          s_tdata,   // data_in
  input  logic                                s_tuser,   // mode
  input  logic                                m_tready,
  output logic                                m_tvalid,
  // data_out[7:0], is_empty[8], is_full[9], line_ready[10], zero pad
  output logic [tle_pkg::TDATA_OUT_W-1:0]     m_tdata,
  output logic [1:0]                          m_tuser,   // kind
  output logic                                m_tlast
);

  import tle_pkg::*;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [PTR_W-1:0] nl, nl_next;
  logic [PTR_W-1:0] tail_inc, tail_dec;
  logic             item_mode;
  logic [7:0]       item_ch;
  seq_t             res_sel, res_sel_next;
  logic [1:0]       res_kind, res_kind_next;
  logic [7:0]       res_b, res_b_next;
  logic [IDX_W-1:0] res_len, res_len_next;
  logic [IDX_W-1:0] res_idx;
  logic             has;
  logic             do_put;
  logic             empty_now, full_now, line_now;
  logic             ram_we;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       rdata;

  assign tail_inc  = ptr_inc(tail);
  assign tail_dec  = ptr_dec(tail);
  assign empty_now = (head == tail);
  assign full_now  = (tail_inc == head);
  assign line_now  = !empty_now && (nl != tail);
  assign ram_raddr = (s_tuser == MODE_READ) ? head : tail_dec;

  tle_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (item_ch),
    .re    (cmd.capture),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    nl_next       = nl;
    res_sel_next  = SEQ_PLAIN;
    res_kind_next = KIND_ECHO;
    res_b_next    = item_ch;
    res_len_next  = IDX_W'(1);
    has           = 1'b0;
    do_put        = 1'b0;
    if (item_mode == MODE_READ) begin
      has           = 1'b1;
      res_kind_next = KIND_READ;
      if (line_enable && !line_now) begin
        res_kind_next = KIND_REFUSE;
        res_b_next    = '0;
      end else if (empty_now) begin
        res_b_next = CH_BANG;
      end else begin
        res_b_next = rdata;
        if (nl == head) begin
          nl_next = tail;
        end
        head_next = ptr_inc(head);
      end
    end else if (!echo_enable) begin
      do_put = 1'b1;
    end else if (item_ch == CH_BS || item_ch == CH_DEL) begin
      if (!empty_now) begin
        if (rdata == CH_LF) begin
          // newline cannot be erased; it stays and marks the line end
          nl_next = tail_dec;
        end else begin
          tail_next = tail_dec;
          if (nl == tail) begin
            nl_next = tail_dec;
          end
          has = 1'b1;
          if (rdata < CTRL_LIMIT) begin
            res_sel_next = SEQ_BS_LONG;
            res_len_next = IDX_W'(6);
          end else begin
            res_sel_next = SEQ_BS_SHORT;
            res_len_next = IDX_W'(3);
          end
        end
      end
    end else begin
      do_put = 1'b1;
      has    = 1'b1;
      if (item_ch == CH_LF) begin
        res_sel_next = SEQ_CRLF;
        res_len_next = IDX_W'(2);
      end else if (item_ch < CTRL_LIMIT) begin
        res_sel_next = SEQ_CARET;
        res_len_next = IDX_W'(2);
        res_b_next   = (item_ch == CH_NUL) ? CH_ZERO : item_ch + CARET_OFS;
      end
    end
    if (do_put && !full_now) begin
      if (item_ch == CH_LF) begin
        nl_next = tail;
      end else if (nl == tail) begin
        nl_next = tail_inc;
      end
      tail_next = tail_inc;
    end
  end

  assign ram_we = cmd.exec && do_put && !full_now;

  assign status.has_results = has;
  assign status.slot_free   = !m_tvalid || m_tready;
  assign status.last_result = (res_idx == res_len - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      nl       <= '0;
      res_len  <= '0;
      res_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        head    <= head_next;
        tail    <= tail_next;
        nl      <= nl_next;
        res_len <= res_len_next;
        res_idx <= '0;
      end else if (cmd.load) begin
        res_idx <= res_idx + 1'b1;
      end
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode <= s_tuser;
      item_ch   <= (s_tdata == CH_CR) ? CH_LF : s_tdata;
    end
    if (cmd.exec) begin
      res_sel  <= res_sel_next;
      res_kind <= res_kind_next;
      res_b    <= res_b_next;
    end
    if (cmd.load) begin
      m_tdata <= {{(TDATA_OUT_W - 11){1'b0}}, line_now, full_now, empty_now,
                  seq_byte(res_sel, res_idx, res_b)};
      m_tuser <= res_kind;
      m_tlast <= status.last_result;
    end
  end

  `TLE_ASSERT_NOW(a_not_empty_and_full, !(empty_now && full_now), "buffer empty and full")
  `TLE_ASSERT_NOW(a_idx_bound, res_idx <= res_len, "result index past sequence length")
  `TLE_ASSERT(a_out_kept, (m_tvalid && !m_tready) |=> m_tvalid, "pending result dropped")

endmodule
